[rtl/core/blid_pkg.sv]
// Shared constants, types and helpers for the bounded list block.
package blid_pkg;

    localparam int CAPACITY = 32;
    localparam int PTR_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int SUM_W    = PTR_W + 1;
    localparam int CMP_W    = 7;
    localparam int VAL_W    = 32;
    localparam int POS_W    = 6;
    localparam int OP_W     = 2;

    localparam logic [OP_W-1:0] OP_FRONT = 2'd0;
    localparam logic [OP_W-1:0] OP_BACK  = 2'd1;
    localparam logic [OP_W-1:0] OP_DEL   = 2'd2;

    typedef struct packed {
        logic             last;
        logic             empty;
        logic             refused;
        logic             shift;
        logic [PTR_W-1:0] pos;
        logic [PTR_W-1:0] wr_addr;
    } blid_tag_t;

    function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
                                                  input logic [SUM_W-1:0] off);
        logic [SUM_W-1:0] s;
        s = SUM_W'(base) + off;
        if (s >= SUM_W'(CAPACITY)) begin
            s = s - SUM_W'(CAPACITY);
        end
        return s[PTR_W-1:0];
    endfunction

endpackage

[rtl/core/blid_ram.sv]
// Simple dual-port RAM with one write port and one registered read port.
module blid_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/blid_seq.sv]
// Request decode, ring pointers and read sequencer for the list walk.
module blid_seq
    import blid_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [OP_W-1:0]         s_op,
    input  logic signed [VAL_W-1:0] s_value,
    input  logic [POS_W-1:0]        s_index,
    input  logic                    stage_busy,
    input  logic                    adv,
    output logic                    issue,
    output blid_tag_t               tag,
    output logic [PTR_W-1:0]        rd_addr,
    output logic                    cmd_we,
    output logic [PTR_W-1:0]        cmd_waddr,
    output logic [VAL_W-1:0]        cmd_wdata
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic             state_reg,   state_next;
    logic [PTR_W-1:0] head_reg,    head_next;
    logic [CNT_W-1:0] count_reg,   count_next;
    logic [PTR_W-1:0] k_reg,       k_next;
    logic             refused_reg, refused_next;
    logic             del_reg,     del_next;
    logic [POS_W-1:0] idx_reg,     idx_next;

    logic             accept;
    logic             full;
    logic             refused_c;
    logic [PTR_W-1:0] head_dec;
    logic             last_c;
    logic             shift_c;
    logic             is_empty;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE) && !stage_busy;
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign head_dec  = (head_reg == '0) ? PTR_W'(CAPACITY - 1) : head_reg - 1'b1;
    assign cmd_wdata = s_value;

    always_comb begin
        refused_c = 1'b0;
        cmd_we    = 1'b0;
        cmd_waddr = head_dec;
        unique case (s_op)
            OP_FRONT: begin
                refused_c = full;
                cmd_we    = accept && !full;
                cmd_waddr = head_dec;
            end
            OP_BACK: begin
                refused_c = full;
                cmd_we    = accept && !full;
                cmd_waddr = wrap_add(head_reg, SUM_W'(count_reg));
            end
            OP_DEL: begin
                refused_c = (CMP_W'(s_index) >= CMP_W'(count_reg));
            end
            default: begin
                refused_c = 1'b1;
            end
        endcase
    end

    assign is_empty = (count_reg == '0);
    assign last_c   = is_empty || ((SUM_W'(k_reg) + SUM_W'(1)) == SUM_W'(count_reg));
    assign shift_c  = del_reg && (CMP_W'(k_reg) >= CMP_W'(idx_reg));
    assign rd_addr  = wrap_add(head_reg, SUM_W'(k_reg) + SUM_W'(shift_c));
    assign issue    = (state_reg == ST_EMIT) && adv;

    always_comb begin
        tag.last    = last_c;
        tag.empty   = is_empty;
        tag.refused = refused_reg;
        tag.shift   = shift_c && !is_empty;
        tag.pos     = k_reg;
        tag.wr_addr = wrap_add(head_reg, SUM_W'(k_reg));
    end

    always_comb begin
        state_next   = state_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        k_next       = k_reg;
        refused_next = refused_reg;
        del_next     = del_reg;
        idx_next     = idx_reg;
        if (accept) begin
            state_next   = ST_EMIT;
            k_next       = '0;
            refused_next = refused_c;
            del_next     = (s_op == OP_DEL) && !refused_c;
            idx_next     = s_index;
            if (!refused_c) begin
                if (s_op == OP_DEL) begin
                    count_next = count_reg - 1'b1;
                end else begin
                    count_next = count_reg + 1'b1;
                end
                if (s_op == OP_FRONT) begin
                    head_next = head_dec;
                end
            end
        end else if (issue) begin
            if (last_c) begin
                state_next = ST_IDLE;
                k_next     = '0;
            end else begin
                k_next = k_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            k_reg       <= '0;
            refused_reg <= 1'b0;
            del_reg     <= 1'b0;
            idx_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            k_reg       <= k_next;
            refused_reg <= refused_next;
            del_reg     <= del_next;
            idx_reg     <= idx_next;
        end
    end

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    a_walk_in_list: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) && !is_empty |-> SUM_W'(k_reg) < SUM_W'(count_reg))
        else $error("walk position beyond list end");

    a_write_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_we |-> accept)
        else $error("list write without accepted request");

endmodule

[rtl/core/bounded_list_insert_delete.sv]
// Bounded ordered list: front/back insert, positional delete, full list walk per request.
// Accepted requests walk the list; each read passes the RAM read register, then the output
// register. A request holding N elements afterwards yields max(N,1) results, one per cycle
// unless m_ready stalls, set by the single RAM read port; no request is taken mid-walk.
// Reset (synchronous, aresetn low) empties the list; RAM contents are not cleared.
module bounded_list_insert_delete
    import blid_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [OP_W-1:0]          s_op,
    input  logic signed [VAL_W-1:0]  s_value,
    input  logic [POS_W-1:0]         s_index,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [VAL_W-1:0]  m_item_value,
    output logic [POS_W-1:0]         m_item_position,
    output logic                     m_last_of_run,
    output logic                     m_list_empty,
    output logic                     m_request_refused
);

    logic                    v1_reg;
    blid_tag_t               tag1_reg;
    logic                    m_valid_reg;
    logic signed [VAL_W-1:0] value_reg;
    logic [POS_W-1:0]        pos_reg;
    logic                    last_reg;
    logic                    empty_reg;
    logic                    refused_reg;

    logic             ready2;
    logic             adv;
    logic             issue;
    blid_tag_t        tag;
    logic [PTR_W-1:0] rd_addr;
    logic             cmd_we;
    logic [PTR_W-1:0] cmd_waddr;
    logic [VAL_W-1:0] cmd_wdata;
    logic             wb_we;
    logic             ram_we;
    logic [PTR_W-1:0] ram_waddr;
    logic [VAL_W-1:0] ram_wdata;
    logic [VAL_W-1:0] rdata;

    assign ready2 = !m_valid_reg || m_ready;
    assign adv    = !v1_reg || ready2;
    assign wb_we  = v1_reg && ready2 && tag1_reg.shift;

    assign ram_we    = cmd_we || wb_we;
    assign ram_waddr = wb_we ? tag1_reg.wr_addr : cmd_waddr;
    assign ram_wdata = wb_we ? rdata : cmd_wdata;

    blid_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_op       (s_op),
        .s_value    (s_value),
        .s_index    (s_index),
        .stage_busy (v1_reg),
        .adv        (adv),
        .issue      (issue),
        .tag        (tag),
        .rd_addr    (rd_addr),
        .cmd_we     (cmd_we),
        .cmd_waddr  (cmd_waddr),
        .cmd_wdata  (cmd_wdata)
    );

    blid_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (VAL_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (issue),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (adv) begin
                v1_reg <= issue;
            end
            if (ready2) begin
                m_valid_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            tag1_reg <= tag;
        end
        if (ready2) begin
            value_reg   <= tag1_reg.empty ? '0 : rdata;
            pos_reg     <= tag1_reg.empty ? '0 : POS_W'(tag1_reg.pos);
            last_reg    <= tag1_reg.last;
            empty_reg   <= tag1_reg.empty;
            refused_reg <= tag1_reg.refused;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_item_value      = value_reg;
    assign m_item_position   = pos_reg;
    assign m_last_of_run     = last_reg;
    assign m_list_empty      = empty_reg;
    assign m_request_refused = refused_reg;

    a_no_write_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd_we && wb_we))
        else $error("request write collides with delete write-back");

    a_idle_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !v1_reg)
        else $error("request accepted while walk still in flight");

    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_list_empty |-> m_last_of_run && (m_item_position == '0))
        else $error("empty-list item malformed");

    a_issue_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        issue |-> adv)
        else $error("read issued into stalled stage");

endmodule

[dv/blid_walk_checker.sv]
// Checker for the bounded list block: tracks the list, predicts each list walk, compares results.
module blid_walk_checker
    import blid_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic [OP_W-1:0]          s_op,
    input  logic signed [VAL_W-1:0]  s_value,
    input  logic [POS_W-1:0]         s_index,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic signed [VAL_W-1:0]  m_item_value,
    input  logic [POS_W-1:0]         m_item_position,
    input  logic                     m_last_of_run,
    input  logic                     m_list_empty,
    input  logic                     m_request_refused,
    output int                       fail_count,
    output int                       pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        position;
        logic                    last;
        logic                    empty;
        logic                    refused;
    } walk_result_t;

    walk_result_t            expected_walk[$];
    logic signed [VAL_W-1:0] list_values[CAPACITY];
    int                      list_len;

    task automatic apply_request(input logic [OP_W-1:0]         op,
                                 input logic signed [VAL_W-1:0] value,
                                 input logic [POS_W-1:0]        index);
        logic         refused;
        walk_result_t entry;
        int           k;
        refused = 1'b0;
        case (op)
            OP_FRONT: begin
                if (list_len >= CAPACITY) begin
                    refused = 1'b1;
                end else begin
                    for (k = list_len; k > 0; k--) begin
                        list_values[k] = list_values[k-1];
                    end
                    list_values[0] = value;
                    list_len++;
                end
            end
            OP_BACK: begin
                if (list_len >= CAPACITY) begin
                    refused = 1'b1;
                end else begin
                    list_values[list_len] = value;
                    list_len++;
                end
            end
            OP_DEL: begin
                if (int'(index) >= list_len) begin
                    refused = 1'b1;
                end else begin
                    for (k = int'(index); k < list_len - 1; k++) begin
                        list_values[k] = list_values[k+1];
                    end
                    list_len--;
                end
            end
            default: begin
                refused = 1'b1;
            end
        endcase
        if (list_len == 0) begin
            entry = '{value: '0, position: '0, last: 1'b1, empty: 1'b1, refused: refused};
            expected_walk.push_back(entry);
        end else begin
            for (k = 0; k < list_len; k++) begin
                entry.value    = list_values[k];
                entry.position = POS_W'(k);
                entry.last     = (k == list_len - 1);
                entry.empty    = 1'b0;
                entry.refused  = refused;
                expected_walk.push_back(entry);
            end
        end
    endtask

    always @(posedge aclk) begin
        walk_result_t want;
        walk_result_t got;
        if (!aresetn) begin
            expected_walk.delete();
            list_len   = 0;
            fail_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                got = '{value: m_item_value, position: m_item_position, last: m_last_of_run,
                        empty: m_list_empty, refused: m_request_refused};
                if (expected_walk.size() == 0) begin
                    if (fail_count < REPORT_LIMIT) begin
                        $display("%0t: unexpected item value=%0d pos=%0d",
                                 $realtime, got.value, got.position,
                                 " last=%0b empty=%0b refused=%0b",
                                 got.last, got.empty, got.refused);
                    end
                    fail_count++;
                end else begin
                    want = expected_walk.pop_front();
                    if (got.value !== want.value || got.position !== want.position ||
                        got.last !== want.last || got.empty !== want.empty ||
                        got.refused !== want.refused) begin
                        if (fail_count < REPORT_LIMIT) begin
                            $display("%0t: mismatch exp value=%0d pos=%0d",
                                     $realtime, want.value, want.position,
                                     " last=%0b empty=%0b refused=%0b",
                                     want.last, want.empty, want.refused);
                            $display("%0t:          got value=%0d pos=%0d",
                                     $realtime, got.value, got.position,
                                     " last=%0b empty=%0b refused=%0b",
                                     got.last, got.empty, got.refused);
                        end
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                apply_request(s_op, s_value, s_index);
            end
        end
        pending_results = expected_walk.size();
    end

endmodule

[dv/tb_bounded_list_insert_delete.sv]
// Testbench top for the bounded list block: clock, reset, request and result traffic, verdict.
module tb_bounded_list_insert_delete
    import blid_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int RESET_CYCLES   = 7;
    localparam int RANDOM_ITEMS   = 290;
    localparam int LONG_HOLD      = 200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;

    logic                    aclk = 1'b0;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    logic [OP_W-1:0]         s_op;
    logic signed [VAL_W-1:0] s_value;
    logic [POS_W-1:0]        s_index;
    logic                    m_valid;
    logic                    m_ready;
    logic signed [VAL_W-1:0] m_item_value;
    logic [POS_W-1:0]        m_item_position;
    logic                    m_last_of_run;
    logic                    m_list_empty;
    logic                    m_request_refused;
    int                      fail_count;
    int                      pending_results;

    int list_len;
    bit send_steady;

    always #1ns aclk = ~aclk;

    bounded_list_insert_delete dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_op              (s_op),
        .s_value           (s_value),
        .s_index           (s_index),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_item_value      (m_item_value),
        .m_item_position   (m_item_position),
        .m_last_of_run     (m_last_of_run),
        .m_list_empty      (m_list_empty),
        .m_request_refused (m_request_refused)
    );

    blid_walk_checker u_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_op              (s_op),
        .s_value           (s_value),
        .s_index           (s_index),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_item_value      (m_item_value),
        .m_item_position   (m_item_position),
        .m_last_of_run     (m_last_of_run),
        .m_list_empty      (m_list_empty),
        .m_request_refused (m_request_refused),
        .fail_count        (fail_count),
        .pending_results   (pending_results)
    );

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 11))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2:       return 32'sh00000000;
            3:       return 32'shffffffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_request(input logic [OP_W-1:0]         op,
                                input logic signed [VAL_W-1:0] value,
                                input logic [POS_W-1:0]        index);
        int gap;
        if ($urandom_range(0, 29) == 0) begin
            send_steady = !send_steady;
        end
        gap = send_steady ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op    <= op;
        s_value <= value;
        s_index <= index;
        do @(posedge aclk); while (!(s_valid && s_ready));
        case (op)
            OP_FRONT, OP_BACK: begin
                if (list_len < CAPACITY) begin
                    list_len++;
                end
            end
            OP_DEL: begin
                if (int'(index) < list_len) begin
                    list_len--;
                end
            end
            default: ;
        endcase
    endtask

    initial begin
        int  stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
        $display("[bounded_list_insert_delete] ERROR");
        $finish;
    end

    initial begin
        int gap;
        int results_taken;
        bit steady;
        m_ready <= 1'b0;
        results_taken = 0;
        steady = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if ($urandom_range(0, 29) == 0) begin
                steady = !steady;
            end
            gap = steady ? 0 : $urandom_range(0, 10);
            if (results_taken == 60 || results_taken == 2500) begin
                gap = LONG_HOLD;
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            results_taken++;
        end
    end

    initial begin
        int  sent;
        int  roll;
        bit  growing;
        list_len    = 0;
        send_steady = 1'b0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_op    <= OP_FRONT;
        s_value <= '0;
        s_index <= '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        send_request(OP_DEL,    32'sh00000000, 6'd0);
        send_request(OP_DEL,    32'sh00000000, 6'd63);
        send_request(OP_UNUSED, 32'shffffffff, 6'd63);
        send_request(OP_FRONT,  32'sh7fffffff, 6'd0);
        send_request(OP_BACK,   32'sh80000000, 6'd63);
        send_request(OP_FRONT,  32'sh00000000, 6'd0);
        send_request(OP_BACK,   32'shffffffff, 6'd0);
        send_request(OP_FRONT,  32'sh55555555, 6'd42);
        send_request(OP_BACK,   32'shaaaaaaaa, 6'd21);
        send_request(OP_DEL,    32'sh00000000, 6'd2);
        send_request(OP_DEL,    32'sh00000000, 6'd0);
        send_request(OP_DEL,    32'sh00000000, 6'd3);
        send_request(OP_DEL,    32'sh00000000, 6'd3);
        send_request(OP_DEL,    32'sh00000000, 6'd63);
        send_request(OP_UNUSED, 32'sh7fffffff, 6'd0);
        send_request(OP_DEL,    32'sh00000000, 6'd0);
        send_request(OP_DEL,    32'sh00000000, 6'd0);
        send_request(OP_DEL,    32'sh00000000, 6'd0);
        send_request(OP_BACK,   32'sh12345678, 6'd0);
        send_request(OP_DEL,    32'sh00000000, 6'd0);

        growing = 1'b1;
        for (sent = 0; sent < RANDOM_ITEMS; sent++) begin
            roll = $urandom_range(0, 99);
            if (roll < 10) begin
                send_request(OP_W'($urandom_range(0, 3)), pick_value(),
                             POS_W'($urandom_range(0, 63)));
            end else if (growing == (roll < 78)) begin
                send_request($urandom_range(0, 1) ? OP_BACK : OP_FRONT, pick_value(),
                             POS_W'($urandom_range(0, 63)));
            end else begin
                send_request(OP_DEL, pick_value(),
                             POS_W'(list_len == 0 ? $urandom_range(0, 63)
                                                  : $urandom_range(0, list_len - 1)));
            end
            if (growing && list_len == CAPACITY && $urandom_range(0, 2) == 0) begin
                growing = 1'b0;
            end else if (!growing && list_len == 0 && $urandom_range(0, 2) == 0) begin
                growing = 1'b1;
            end
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        wait (pending_results == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending_results == 0) begin
            $display("[bounded_list_insert_delete] OK");
        end else begin
            $display("[bounded_list_insert_delete] ERROR");
        end
        $finish;
    end

endmodule
